[hdl/frbm_pkg.sv]
// ----------------------------------------------------------------------------
// FXO ring and battery monitor package
// Payload types, register indexes, event codes and fixed constants shared by
// the monitor top level and its testbench-facing ports.
// ----------------------------------------------------------------------------
package frbm_pkg;

    // Input transaction payload.
    typedef struct packed {
        logic               opcode;
        logic [1:0]         card;
        logic               offhook;
        logic [7:0]         daa_status;
        logic signed [7:0]  line_voltage;
        logic signed [15:0] audio_sample;
        logic               chunk_first;
        logic               chunk_last;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic       status_write_valid;
        logic [7:0] status_write_value;
        logic [1:0] ring_event;
        logic [1:0] battery_event;
    } out_item_t;

    // Item kinds.
    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_BATTERY_THRESHOLD = 3'd0,
        REG_BATTERY_DEBOUNCE  = 3'd1,
        REG_PEG_WINDOW_MAX    = 3'd2,
        REG_PEG_WINDOW_MIN    = 3'd3,
        REG_PEG_COUNT_NEEDED  = 3'd4
    } cfg_index_t;

    // Event codes.
    localparam logic [1:0] RING_NONE     = 2'd0;
    localparam logic [1:0] RING_START    = 2'd1;
    localparam logic [1:0] RING_END      = 2'd2;
    localparam logic [1:0] BATT_NONE     = 2'd0;
    localparam logic [1:0] BATT_LOST     = 2'd1;
    localparam logic [1:0] BATT_RESTORED = 2'd2;

    // Polarity of the last counted peak.
    localparam logic [1:0] POL_NONE = 2'd0;
    localparam logic [1:0] POL_HIGH = 2'd1;
    localparam logic [1:0] POL_LOW  = 2'd2;

    // DAA status byte decoding.
    localparam logic [7:0] STATUS_MASK = 8'h9b;
    localparam logic [7:0] RING_BITS   = 8'h60;
    localparam logic [7:0] BAD_BIT     = 8'h02;
    localparam logic [7:0] GOOD_BIT    = 8'h08;
    localparam logic [7:0] ST_ONHOOK   = 8'h08;
    localparam logic [7:0] ST_OFFHOOK  = 8'h09;

    // Peak detection level for ringing.
    localparam logic signed [15:0] PEAK_LEVEL_POS = 16'sd10000;
    localparam logic signed [15:0] PEAK_LEVEL_NEG = -16'sd10000;

    // Configuration reset values.
    localparam logic [7:0]  RST_BATTERY_THRESHOLD = 8'd3;
    localparam logic [7:0]  RST_BATTERY_DEBOUNCE  = 8'd16;
    localparam logic [15:0] RST_PEG_WINDOW_MAX    = 16'd400;
    localparam logic [15:0] RST_PEG_WINDOW_MIN    = 16'd80;
    localparam logic [7:0]  RST_PEG_COUNT_NEEDED  = 8'd5;

endpackage

[hdl/frbm_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and returns the
// contents before a same-cycle write to the same address.
// ----------------------------------------------------------------------------
module frbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/fxo_ring_battery_monitor_unit.sv]
// ----------------------------------------------------------------------------
// FXO ring and battery monitor
// Per-card line monitor: status rewrite, ring debounce, battery loss and
// restore detection, and ringing detection from alternating audio peaks.
// ----------------------------------------------------------------------------
// Usage: each input transaction on s_* is either a status poll or one audio
// sample for one line card and gives exactly one result on m_*, in order.
// Configuration registers are written through cfg_* (cfg_ready is always
// high); the user must do so only while idle; the block does not enforce it.
//
// The card's state is read from the state memory when a transaction is
// accepted, and the next state and the result are computed in the compute
// stage and written back together with the output register load that sets
// m_valid. Throughput is one transaction per cycle for any mix of cards while
// the receiver keeps up. It is set by the state memory, which gets one read
// and one write each cycle; a write to the card that the next transaction
// has just read is forwarded from a holding register.
//
// Reset loads the configuration defaults and clears the per-entry valid
// bits, so every card's state reads as zero until first written. When the
// receiver stalls, the result waits in the output register, one more
// transaction may wait in the compute stage, and s_ready then drops.
// ----------------------------------------------------------------------------
module fxo_ring_battery_monitor_unit #(
    parameter int NUM_CARDS  = 4,
    parameter int CHUNK_SIZE = 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  frbm_pkg::in_item_t  s_data,

    output logic                m_valid,
    input  logic                m_ready,
    output frbm_pkg::out_item_t m_data,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    // Address width of the card state memory.
    localparam int CARD_AW = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1;
    // Ring debounce ceiling and the width that holds it.
    localparam int RD_TOP_INT = CHUNK_SIZE * 64;
    localparam int RD_W       = $clog2(RD_TOP_INT + 1);
    localparam logic [RD_W-1:0] RD_TOP  = RD_W'(RD_TOP_INT);
    localparam logic [RD_W-1:0] RD_DOWN = RD_W'(CHUNK_SIZE);
    localparam logic [RD_W:0]   RD_UP   = (RD_W + 1)'(CHUNK_SIZE * 4);
    localparam logic [16:0]     PT_STEP = 17'(CHUNK_SIZE);

    // One card's state as stored in the memory.
    typedef struct packed {
        logic [RD_W-1:0] ring_debounce;
        logic            was_ringing;
        logic            battery_present;
        logic [7:0]      batt_count;
        logic [15:0]     peak_timer;
        logic [1:0]      peak_pol;
        logic [7:0]      peak_count;
        logic            ring_active;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Configuration registers.
    logic [7:0]  batt_thr_reg;
    logic [7:0]  batt_deb_reg;
    logic [15:0] peg_max_reg;
    logic [15:0] peg_min_reg;
    logic [7:0]  peg_need_reg;

    // Compute stage.
    logic               s1_valid_reg;
    frbm_pkg::in_item_t s1_item_reg;
    logic [CARD_AW-1:0] s1_addr_reg;
    logic               s1_in_range_reg;
    logic               s1_hit_reg;

    // Last write into the state memory, for forwarding.
    logic               fwd_valid_reg;
    logic [CARD_AW-1:0] fwd_addr_reg;
    entry_t             fwd_data_reg;

    // Valid bit per card entry; an entry never written reads as zero.
    logic [NUM_CARDS-1:0] entry_valid_reg;

    // Output register.
    logic                m_valid_reg;
    frbm_pkg::out_item_t m_data_reg;

    // Datapath signals.
    logic [CARD_AW+1:0]  card_ext;
    logic [CARD_AW-1:0]  in_addr;
    logic                in_range;
    logic                in_accept;
    logic                advance;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              entry_cur;
    entry_t              entry_next;
    frbm_pkg::out_item_t result;
    logic [7:0]          poll_target;
    logic [RD_W:0]       rd_sum;
    logic [8:0]          volt_mag;
    logic [16:0]         pt_sum;
    logic [15:0]         win_hi;
    logic [15:0]         win_lo;

    // ------------------------------------------------------------------
    // Configuration port. Writes beyond the register list are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batt_thr_reg <= frbm_pkg::RST_BATTERY_THRESHOLD;
            batt_deb_reg <= frbm_pkg::RST_BATTERY_DEBOUNCE;
            peg_max_reg  <= frbm_pkg::RST_PEG_WINDOW_MAX;
            peg_min_reg  <= frbm_pkg::RST_PEG_WINDOW_MIN;
            peg_need_reg <= frbm_pkg::RST_PEG_COUNT_NEEDED;
        end else if (cfg_valid) begin
            case (cfg_index)
                frbm_pkg::REG_BATTERY_THRESHOLD: batt_thr_reg <= cfg_data[7:0];
                frbm_pkg::REG_BATTERY_DEBOUNCE:  batt_deb_reg <= cfg_data[7:0];
                frbm_pkg::REG_PEG_WINDOW_MAX:    peg_max_reg  <= cfg_data;
                frbm_pkg::REG_PEG_WINDOW_MIN:    peg_min_reg  <= cfg_data;
                frbm_pkg::REG_PEG_COUNT_NEEDED:  peg_need_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The compute stage moves on whenever the output register
    // is free or being emptied, so a new transaction is taken every cycle
    // while the receiver keeps up.
    // ------------------------------------------------------------------
    assign advance   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || advance;
    assign in_accept = s_valid && s_ready;
    assign ram_we    = advance && s1_in_range_reg;

    // Card indexes at or above NUM_CARDS touch no state.
    assign card_ext = {{CARD_AW{1'b0}}, s_data.card};
    assign in_addr  = card_ext[CARD_AW-1:0];
    assign in_range = card_ext < (CARD_AW + 2)'(NUM_CARDS);

    frbm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CARDS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (entry_next),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                fwd_valid_reg                <= 1'b1;
                entry_valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg     <= s_data;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_hit_reg      <= in_range && entry_valid_reg[in_addr];
        end
        if (ram_we) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= entry_next;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The most recent write always holds the newest contents of its entry,
    // so it takes precedence over the memory read whenever the card matches.
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            entry_cur = fwd_data_reg;
        end else if (s1_hit_reg) begin
            entry_cur = entry_t'(ram_rdata);
        end else begin
            entry_cur = '0;
        end
    end

    // ------------------------------------------------------------------
    // Next state and result for the transaction in the compute stage.
    // ------------------------------------------------------------------
    always_comb begin
        entry_next  = entry_cur;
        result      = '0;
        poll_target = s1_item_reg.offhook ? frbm_pkg::ST_OFFHOOK : frbm_pkg::ST_ONHOOK;
        rd_sum      = {1'b0, entry_cur.ring_debounce} + RD_UP;
        volt_mag    = s1_item_reg.line_voltage[7]
                    ? (9'h100 - {1'b0, s1_item_reg.line_voltage})
                    : {1'b0, s1_item_reg.line_voltage};
        pt_sum      = {1'b0, entry_cur.peak_timer} + PT_STEP;
        win_hi      = peg_max_reg;
        win_lo      = peg_min_reg;

        if (s1_item_reg.opcode == frbm_pkg::OP_POLL) begin
            result.status_write_valid =
                (s1_item_reg.daa_status & frbm_pkg::STATUS_MASK) != poll_target;
            result.status_write_value = poll_target;

            // A status byte with the bad bit set or the good bit clear stops the poll after the status rewrite.
            if (((s1_item_reg.daa_status & frbm_pkg::BAD_BIT) == '0) &&
                ((s1_item_reg.daa_status & frbm_pkg::GOOD_BIT) != '0)) begin
                // Ring indicator debounce, only while on hook.
                if (!s1_item_reg.offhook) begin
                    if (((s1_item_reg.daa_status & frbm_pkg::RING_BITS) != '0) &&
                        entry_cur.battery_present) begin
                        if (rd_sum >= {1'b0, RD_TOP}) begin
                            if (!entry_cur.was_ringing) begin
                                entry_next.was_ringing = 1'b1;
                                result.ring_event      = frbm_pkg::RING_START;
                            end
                            entry_next.ring_debounce = RD_TOP;
                        end else begin
                            entry_next.ring_debounce = rd_sum[RD_W-1:0];
                        end
                    end else if (entry_cur.ring_debounce <= RD_DOWN) begin
                        if (entry_cur.was_ringing) begin
                            entry_next.was_ringing = 1'b0;
                            result.ring_event      = frbm_pkg::RING_END;
                        end
                        entry_next.ring_debounce = '0;
                    end else begin
                        entry_next.ring_debounce = entry_cur.ring_debounce - RD_DOWN;
                    end
                end

                // Battery loss and restore with a reload-and-count-down debounce.
                if (volt_mag < {1'b0, batt_thr_reg}) begin
                    if (entry_cur.battery_present && (entry_cur.batt_count == '0)) begin
                        entry_next.battery_present = 1'b0;
                        result.battery_event       = frbm_pkg::BATT_LOST;
                        entry_next.batt_count      = batt_deb_reg;
                    end else if (!entry_cur.battery_present) begin
                        entry_next.batt_count = batt_deb_reg;
                    end
                end else if (volt_mag > {1'b0, batt_thr_reg}) begin
                    if (!entry_cur.battery_present && (entry_cur.batt_count == '0)) begin
                        entry_next.battery_present = 1'b1;
                        result.battery_event       = frbm_pkg::BATT_RESTORED;
                        entry_next.batt_count      = batt_deb_reg;
                    end else if (entry_cur.battery_present) begin
                        entry_next.batt_count = batt_deb_reg;
                    end
                end else begin
                    entry_next.batt_count = batt_deb_reg;
                end
                if (entry_next.batt_count != '0) begin
                    entry_next.batt_count = entry_next.batt_count - 8'd1;
                end
            end
        end else begin
            // Peak timer advances once per chunk and saturates.
            if (s1_item_reg.chunk_first) begin
                entry_next.peak_timer = pt_sum[16] ? 16'hffff : pt_sum[15:0];
            end

            // A peak of the opposite polarity closes one spacing interval.
            // Negative peaks use a window a quarter the size.
            if ((s1_item_reg.audio_sample > frbm_pkg::PEAK_LEVEL_POS) &&
                (entry_cur.peak_pol != frbm_pkg::POL_HIGH)) begin
                if ((entry_next.peak_timer < win_hi) && (entry_next.peak_timer > win_lo) &&
                    (entry_cur.peak_count != 8'hff)) begin
                    entry_next.peak_count = entry_cur.peak_count + 8'd1;
                end
                entry_next.peak_timer = '0;
                entry_next.peak_pol   = frbm_pkg::POL_HIGH;
            end else if ((s1_item_reg.audio_sample < frbm_pkg::PEAK_LEVEL_NEG) &&
                         (entry_cur.peak_pol != frbm_pkg::POL_LOW)) begin
                if ((entry_next.peak_timer < {2'b00, win_hi[15:2]}) &&
                    (entry_next.peak_timer > {2'b00, win_lo[15:2]}) &&
                    (entry_cur.peak_count != 8'hff)) begin
                    entry_next.peak_count = entry_cur.peak_count + 8'd1;
                end
                entry_next.peak_timer = '0;
                entry_next.peak_pol   = frbm_pkg::POL_LOW;
            end

            // End of chunk: time out the peak count, count down the ring debounce and decide on ringing.
            if (s1_item_reg.chunk_last) begin
                if (entry_next.peak_timer > peg_max_reg) begin
                    entry_next.peak_count = '0;
                end
                if (entry_cur.ring_debounce != '0) begin
                    entry_next.ring_debounce = entry_cur.ring_debounce - RD_W'(1);
                end
                if (!s1_item_reg.offhook && (entry_next.ring_debounce == '0)) begin
                    if (!entry_cur.ring_active && (entry_next.peak_count > peg_need_reg)) begin
                        entry_next.ring_active = 1'b1;
                        result.ring_event      = frbm_pkg::RING_START;
                    end else if (entry_cur.ring_active && (entry_next.peak_count == '0)) begin
                        entry_next.ring_active = 1'b0;
                        result.ring_event      = frbm_pkg::RING_END;
                    end
                end
            end
        end

        if (!s1_in_range_reg) begin
            result = '0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A poll with a bad status byte reports no ring or battery event.
    a_bad_status_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (s1_item_reg.opcode == frbm_pkg::OP_POLL) &&
         ((s1_item_reg.daa_status & frbm_pkg::BAD_BIT) != '0))
        |=> (m_data.ring_event == frbm_pkg::RING_NONE) &&
            (m_data.battery_event == frbm_pkg::BATT_NONE))
        else $error("bad status poll produced an event");

    // A sample never asks for a status rewrite or reports a battery event.
    a_sample_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (s1_item_reg.opcode == frbm_pkg::OP_SAMPLE))
        |=> !m_data.status_write_valid && (m_data.battery_event == frbm_pkg::BATT_NONE))
        else $error("sample result carries poll fields");

    // Every state write is captured for forwarding to the next transaction.
    a_forward_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> fwd_valid_reg && (fwd_addr_reg == $past(s1_addr_reg)) &&
                   entry_valid_reg[fwd_addr_reg])
        else $error("state write not captured for forwarding");

    // The ring debounce count never passes its ceiling.
    a_debounce_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (entry_next.ring_debounce <= RD_TOP))
        else $error("ring debounce above ceiling");

endmodule
